>>> rtl/etok_pkg.sv
// etok_pkg: token kinds, error causes and result word types of the byte tokenizer
package etok_pkg;

  // token kinds
  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_INT    = 4'd1;
  localparam logic [3:0] KIND_LPAREN = 4'd2;
  localparam logic [3:0] KIND_RPAREN = 4'd3;
  localparam logic [3:0] KIND_PLUS   = 4'd4;
  localparam logic [3:0] KIND_MINUS  = 4'd5;
  localparam logic [3:0] KIND_STAR   = 4'd6;
  localparam logic [3:0] KIND_SLASH  = 4'd7;
  localparam logic [3:0] KIND_PCT    = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;
  localparam logic [3:0] KIND_ERROR  = 4'd10;

  // error causes
  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_IDENT_LEN = 3'd1;
  localparam logic [2:0] CAUSE_OVERFLOW  = 3'd2;
  localparam logic [2:0] CAUSE_BAD_HEX   = 3'd3;
  localparam logic [2:0] CAUSE_BAD_INT   = 3'd4;
  localparam logic [2:0] CAUSE_BAD_CHAR  = 3'd5;
  localparam logic [2:0] CAUSE_TOK_LIMIT = 3'd6;
  localparam logic [2:0] CAUSE_TOO_LONG  = 3'd7;

  // most result words one input byte can cause
  localparam int unsigned GRP_SLOTS = 3;

  // one result word
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [8:0]  token_offset;
    logic [8:0]  token_length;
    logic [63:0] literal_value;
    logic [2:0]  error_cause;
    logic        run_last;
  } etok_res_t;

  // all result words of one input byte
  typedef struct packed {
    logic [1:0]                     count;
    etok_res_t [GRP_SLOTS-1:0]      item;
  } etok_grp_t;

endpackage

>>> rtl/etok_channels.sv
// etok_channels: valid/ready channel interfaces for input bytes and result words

interface etok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       final_byte;

  modport source (output valid, output char_byte, output final_byte, input ready);
  modport sink   (input valid, input char_byte, input final_byte, output ready);
endinterface

interface etok_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [8:0]  token_offset;
  logic [8:0]  token_length;
  logic [63:0] literal_value;
  logic [2:0]  error_cause;
  logic        run_last;

  modport source (output valid, output token_kind, output token_offset, output token_length,
                  output literal_value, output error_cause, output run_last, input ready);
  modport sink   (input valid, input token_kind, input token_offset, input token_length,
                  input literal_value, input error_cause, input run_last, output ready);
endinterface

>>> rtl/etok_lex.sv
// etok_lex: lexer state registers and the per-byte token logic
module etok_lex #(
  parameter int unsigned MAX_IDENT_BYTES = 32,
  parameter int unsigned MAX_TOKENS      = 64,
  parameter int unsigned MAX_EXPR_BYTES  = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_i,
  input  logic [7:0]         char_i,
  input  logic               final_i,
  output etok_pkg::etok_grp_t grp_o
);
  import etok_pkg::*;

  localparam int unsigned OFF_W = $clog2(MAX_EXPR_BYTES + 1);
  localparam int unsigned TOK_W = $clog2(MAX_TOKENS + 1);
  localparam int unsigned ID_W  = $clog2(MAX_IDENT_BYTES + 1);
  localparam int unsigned SUM_W = (OFF_W >= 9) ? OFF_W + 1 : 10;

  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_EXPR_BYTES);
  localparam logic [TOK_W-1:0] TOK_MAX = TOK_W'(MAX_TOKENS);
  localparam logic [ID_W-1:0]  ID_MAX  = ID_W'(MAX_IDENT_BYTES);

  // lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_DEC     = 3'd2;
  localparam logic [2:0] MODE_ZERO    = 3'd3;
  localparam logic [2:0] MODE_HEXPFX  = 3'd4;
  localparam logic [2:0] MODE_HEX     = 3'd5;
  localparam logic [2:0] MODE_DISCARD = 3'd6;

  // character classes
  function automatic logic is_lead(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    // space, tab, carriage return, line feed
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // single-byte token kind, KIND_ERROR when the byte is no operator
  function automatic logic [3:0] op_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PCT;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic etok_res_t mk_res(input logic [3:0] kind, input logic [8:0] off,
                                       input logic [8:0] len, input logic [63:0] val,
                                       input logic [2:0] cause);
    etok_res_t r;
    r.token_kind    = kind;
    r.token_offset  = off;
    r.token_length  = len;
    r.literal_value = val;
    r.error_cause   = cause;
    r.run_last      = 1'b0;
    return r;
  endfunction

  // state registers
  logic [2:0]       mode_r, mode_nxt;
  logic [OFF_W-1:0] start_r, start_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [ID_W-1:0]  dcnt_r, dcnt_nxt;
  logic [TOK_W-1:0] tok_r, tok_nxt;

  // per-byte working values
  etok_res_t [GRP_SLOTS-1:0] res_v;
  logic [1:0]       n_v;
  logic             pend_v;
  logic [3:0]       pkind_v;
  logic             open_v;
  logic             ok_v;
  logic [3:0]       okind_v;
  logic [SUM_W-1:0] o_ext;
  logic [SUM_W-1:0] len_v;
  logic [SUM_W-1:0] end_v;
  logic [4:0]       hexd;
  logic [67:0]      dec_sum;
  logic             dec_ovf;
  logic             hex_ovf;

  // accumulate step: decimal x10 + d with carry-out check, hex shift with top-nibble check
  always_comb begin
    hexd    = hex_nibble(char_i);
    dec_sum = (68'(acc_r) << 3) + (68'(acc_r) << 1) + 68'(hexd[3:0]);
    dec_ovf = |dec_sum[67:64];
    hex_ovf = |acc_r[63:60];
  end

  // token logic for one byte: length limit, pending close, new token, end of expression
  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    tok_nxt   = tok_r;
    res_v     = '0;
    n_v       = 2'd0;
    pend_v    = 1'b0;
    pkind_v   = KIND_IDENT;
    open_v    = 1'b0;
    ok_v      = 1'b1;
    okind_v   = op_kind(char_i);
    o_ext     = SUM_W'(off_r);
    len_v     = '0;
    end_v     = o_ext + SUM_W'(1);

    if (mode_r != MODE_DISCARD) begin
      if (off_r >= OFF_MAX) begin
        res_v[n_v] = mk_res(KIND_ERROR, 9'd0, 9'd0, 64'd0, CAUSE_TOO_LONG);
        n_v        = n_v + 2'd1;
        mode_nxt   = MODE_DISCARD;
      end else begin
        // continue or close the pending token
        case (mode_r)
          MODE_IDENT: begin
            if (is_lead(char_i) || is_digit(char_i)) begin
              dcnt_nxt = dcnt_r + ID_W'(1);
              if (dcnt_nxt >= ID_MAX) begin
                res_v[n_v] = mk_res(KIND_ERROR, 9'(start_r), 9'd0, 64'd0, CAUSE_IDENT_LEN);
                n_v        = n_v + 2'd1;
                mode_nxt   = MODE_DISCARD;
              end
            end else begin
              pend_v  = 1'b1;
              pkind_v = KIND_IDENT;
            end
          end
          MODE_ZERO, MODE_DEC: begin
            if (mode_r == MODE_ZERO && (char_i == "x" || char_i == "X")) begin
              mode_nxt = MODE_HEXPFX;
              acc_nxt  = 64'd0;
            end else if (is_digit(char_i)) begin
              mode_nxt = MODE_DEC;
              if (dec_ovf) begin
                res_v[n_v] = mk_res(KIND_ERROR, 9'(start_r), 9'd0, 64'd0, CAUSE_OVERFLOW);
                n_v        = n_v + 2'd1;
                mode_nxt   = MODE_DISCARD;
              end else begin
                acc_nxt = dec_sum[63:0];
              end
            end else if (is_lead(char_i)) begin
              res_v[n_v] = mk_res(KIND_ERROR, o_ext[8:0], 9'd0, 64'd0, CAUSE_BAD_INT);
              n_v        = n_v + 2'd1;
              mode_nxt   = MODE_DISCARD;
            end else begin
              pend_v  = 1'b1;
              pkind_v = KIND_INT;
            end
          end
          MODE_HEXPFX, MODE_HEX: begin
            if (hexd[4]) begin
              mode_nxt = MODE_HEX;
              if (hex_ovf) begin
                res_v[n_v] = mk_res(KIND_ERROR, 9'(start_r), 9'd0, 64'd0, CAUSE_OVERFLOW);
                n_v        = n_v + 2'd1;
                mode_nxt   = MODE_DISCARD;
              end else begin
                acc_nxt = {acc_r[59:0], hexd[3:0]};
              end
            end else if (mode_r == MODE_HEXPFX) begin
              res_v[n_v] = mk_res(KIND_ERROR, 9'(start_r), 9'd0, 64'd0, CAUSE_BAD_HEX);
              n_v        = n_v + 2'd1;
              mode_nxt   = MODE_DISCARD;
            end else if (is_lead(char_i)) begin
              res_v[n_v] = mk_res(KIND_ERROR, o_ext[8:0], 9'd0, 64'd0, CAUSE_BAD_INT);
              n_v        = n_v + 2'd1;
              mode_nxt   = MODE_DISCARD;
            end else begin
              pend_v  = 1'b1;
              pkind_v = KIND_INT;
            end
          end
          MODE_IDLE: begin
            open_v = 1'b1;
          end
          default: begin
          end
        endcase

        // emit the token this byte closed
        if (pend_v) begin
          if (tok_nxt >= TOK_MAX) begin
            res_v[n_v] = mk_res(KIND_ERROR, 9'(start_r), 9'd0, 64'd0, CAUSE_TOK_LIMIT);
            n_v        = n_v + 2'd1;
            mode_nxt   = MODE_DISCARD;
          end else begin
            len_v      = o_ext - SUM_W'(start_r);
            res_v[n_v] = mk_res(pkind_v, 9'(start_r), len_v[8:0],
                                (pkind_v == KIND_INT) ? acc_r : 64'd0, CAUSE_NONE);
            n_v        = n_v + 2'd1;
            tok_nxt    = tok_nxt + TOK_W'(1);
            open_v     = 1'b1;
          end
        end

        // start a new token at this byte
        if (open_v) begin
          mode_nxt = MODE_IDLE;
          if (is_space(char_i)) begin
            mode_nxt = MODE_IDLE;
          end else if (is_lead(char_i)) begin
            mode_nxt  = MODE_IDENT;
            start_nxt = off_r;
            dcnt_nxt  = ID_W'(1);
          end else if (is_digit(char_i)) begin
            start_nxt = off_r;
            acc_nxt   = {60'd0, hexd[3:0]};
            mode_nxt  = (char_i == "0") ? MODE_ZERO : MODE_DEC;
          end else if (okind_v != KIND_ERROR) begin
            if (tok_nxt >= TOK_MAX) begin
              res_v[n_v] = mk_res(KIND_ERROR, o_ext[8:0], 9'd0, 64'd0, CAUSE_TOK_LIMIT);
              n_v        = n_v + 2'd1;
              mode_nxt   = MODE_DISCARD;
            end else begin
              res_v[n_v] = mk_res(okind_v, o_ext[8:0], 9'd1, 64'd0, CAUSE_NONE);
              n_v        = n_v + 2'd1;
              tok_nxt    = tok_nxt + TOK_W'(1);
            end
          end else begin
            res_v[n_v] = mk_res(KIND_ERROR, o_ext[8:0], 9'd0, 64'd0, CAUSE_BAD_CHAR);
            n_v        = n_v + 2'd1;
            mode_nxt   = MODE_DISCARD;
          end
        end

        // last byte: close the open token, then the end token
        if (final_i && mode_nxt != MODE_DISCARD) begin
          len_v = end_v - SUM_W'(start_nxt);
          case (mode_nxt)
            MODE_IDENT, MODE_ZERO, MODE_DEC, MODE_HEX: begin
              if (tok_nxt >= TOK_MAX) begin
                res_v[n_v] = mk_res(KIND_ERROR, 9'(start_nxt), 9'd0, 64'd0, CAUSE_TOK_LIMIT);
                n_v        = n_v + 2'd1;
                mode_nxt   = MODE_DISCARD;
                ok_v       = 1'b0;
              end else begin
                res_v[n_v] = mk_res((mode_nxt == MODE_IDENT) ? KIND_IDENT : KIND_INT,
                                    9'(start_nxt), len_v[8:0],
                                    (mode_nxt == MODE_IDENT) ? 64'd0 : acc_nxt, CAUSE_NONE);
                n_v        = n_v + 2'd1;
                tok_nxt    = tok_nxt + TOK_W'(1);
              end
            end
            MODE_HEXPFX: begin
              res_v[n_v] = mk_res(KIND_ERROR, 9'(start_nxt), 9'd0, 64'd0, CAUSE_BAD_HEX);
              n_v        = n_v + 2'd1;
              mode_nxt   = MODE_DISCARD;
              ok_v       = 1'b0;
            end
            default: begin
            end
          endcase
          if (ok_v) begin
            if (tok_nxt >= TOK_MAX) begin
              res_v[n_v] = mk_res(KIND_ERROR, end_v[8:0], 9'd0, 64'd0, CAUSE_TOK_LIMIT);
              n_v        = n_v + 2'd1;
              mode_nxt   = MODE_DISCARD;
            end else begin
              res_v[n_v] = mk_res(KIND_END, end_v[8:0], 9'd0, 64'd0, CAUSE_NONE);
              n_v        = n_v + 2'd1;
              tok_nxt    = tok_nxt + TOK_W'(1);
            end
          end
        end
      end
    end

    // mark the last word of this byte
    if (n_v != 2'd0) begin
      res_v[n_v - 2'd1].run_last = 1'b1;
    end

    // byte offset saturates at the expression limit
    off_nxt = (off_r >= OFF_MAX) ? off_r : off_r + OFF_W'(1);

    // last byte returns everything to reset
    if (final_i) begin
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      off_nxt   = '0;
      acc_nxt   = 64'd0;
      dcnt_nxt  = '0;
      tok_nxt   = '0;
    end
  end

  assign grp_o.count = n_v;
  assign grp_o.item  = res_v;

  // state update once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      off_r   <= '0;
      acc_r   <= 64'd0;
      dcnt_r  <= '0;
      tok_r   <= '0;
    end else if (step_i) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      off_r   <= off_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      tok_r   <= tok_nxt;
    end
  end

endmodule

>>> rtl/etok_outq.sv
// etok_outq: three-slot result register that drains one word per handshake
module etok_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  etok_pkg::etok_grp_t grp_i,
  input  logic                ready_i,
  output logic                can_load_o,
  output logic                valid_o,
  output etok_pkg::etok_res_t head_o
);
  import etok_pkg::*;

  etok_res_t [GRP_SLOTS-1:0] slot_r;
  logic [1:0]                cnt_r;
  logic                      pop;

  assign valid_o    = (cnt_r != 2'd0);
  assign head_o     = slot_r[0];
  assign pop        = valid_o && ready_i;
  // a new group may enter once the slots are empty after this cycle
  assign can_load_o = (cnt_r == 2'd0) || (cnt_r == 2'd1 && ready_i);

  // word count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load_i) begin
      cnt_r <= grp_i.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // slot payload, shifted toward the head on each taken word
  always_ff @(posedge clk) begin
    if (load_i) begin
      slot_r <= grp_i.item;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule

>>> rtl/expression_byte_tokenizer_core.sv
// expression_byte_tokenizer_core: top level of the streaming expression tokenizer
//
// One expression byte enters per word on in_chan, final_byte marks the last byte
// of an expression. Tokens leave on out_chan as they complete, one word per token:
// identifiers, integer literals with their value, parentheses, operators, then an
// end token on the last byte. The first lexing error leaves as one error word and
// the rest of that expression gives nothing; the last byte resets the lexer.
// run_last marks the last word caused by an input byte.
// The first word of a byte reaches out_chan through the byte register and then
// the result slots, both registered.
// One byte per cycle while each byte yields at most one word and out_chan takes
// every word; a byte that yields more words holds the input until the result
// slots drain, as they drain one word per handshake.
// A byte register in front and the result slots behind let a new byte be taken
// while the last word of the previous one still waits on out_chan.
// When out_chan stalls the words hold steady and in_chan.ready drops once the byte
// register is full. Synchronous active-low reset empties both registers and
// returns the lexer to idle at offset zero.
module expression_byte_tokenizer_core #(
  parameter int unsigned MAX_IDENT_BYTES = 32,
  parameter int unsigned MAX_TOKENS      = 64,
  parameter int unsigned MAX_EXPR_BYTES  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  etok_in_if.sink           in_chan,
  etok_out_if.source        out_chan
);
  import etok_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_fin_r;
  logic       step;
  logic       can_load;
  logic       in_take;
  etok_grp_t  grp;
  etok_res_t  head;

  // byte register in front of the lexer
  assign step          = in_vld_r && can_load;
  assign in_chan.ready = !in_vld_r || step;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_chan.char_byte;
      in_fin_r  <= in_chan.final_byte;
    end
  end

  // lexer
  etok_lex #(
    .MAX_IDENT_BYTES (MAX_IDENT_BYTES),
    .MAX_TOKENS      (MAX_TOKENS),
    .MAX_EXPR_BYTES  (MAX_EXPR_BYTES)
  ) u_lex (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .char_i  (in_byte_r),
    .final_i (in_fin_r),
    .grp_o   (grp)
  );

  // result slots
  etok_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (step),
    .grp_i      (grp),
    .ready_i    (out_chan.ready),
    .can_load_o (can_load),
    .valid_o    (out_chan.valid),
    .head_o     (head)
  );

  assign out_chan.token_kind    = head.token_kind;
  assign out_chan.token_offset  = head.token_offset;
  assign out_chan.token_length  = head.token_length;
  assign out_chan.literal_value = head.literal_value;
  assign out_chan.error_cause   = head.error_cause;
  assign out_chan.run_last      = head.run_last;

endmodule

>>> rtl/etok_checker.sv
// etok_checker: port-level assertions for the tokenizer core and its bind
module etok_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [8:0]  out_length,
  input logic [63:0] out_literal,
  input logic [2:0]  out_cause,
  input logic        out_last
);
  import etok_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_literal))
    else $error("result word changed while stalled");

  // words of one byte come without gaps
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside the words of one byte");

  // only error words carry a cause
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERROR) == (out_cause != CAUSE_NONE)))
    else $error("error cause does not match token kind");

  // end and error words have no length and no value
  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_END || out_kind == KIND_ERROR)
      |-> out_length == 9'd0 && out_literal == 64'd0)
    else $error("end or error word with length or value");

endmodule

bind expression_byte_tokenizer_core etok_checker u_etok_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_kind    (out_chan.token_kind),
  .out_length  (out_chan.token_length),
  .out_literal (out_chan.literal_value),
  .out_cause   (out_chan.error_cause),
  .out_last    (out_chan.run_last)
);

>>> test/tb_expression_byte_tokenizer_core.sv
// testbench for expression_byte_tokenizer_core: random expressions checked against a token predictor

import etok_pkg::*;

typedef enum logic [2:0] {
  LX_IDLE, LX_IDENT, LX_DEC, LX_ZERO, LX_HEXPFX, LX_HEX, LX_DISCARD
} lex_mode_t;

// predicts the token words of each accepted byte and checks them in order
class token_tracker;
  etok_res_t tokens_due[$];
  etok_res_t step_words[$];
  int errors;
  int ident_cap;
  int tok_cap;
  int expr_cap;
  lex_mode_t mode;
  int tok_start;
  int byte_pos;
  int char_count;
  int tok_count;
  logic [63:0] acc;

  function new(int ident_max, int tok_max, int expr_max);
    ident_cap = ident_max;
    tok_cap = tok_max;
    expr_cap = expr_max;
    errors = 0;
    restart();
  endfunction

  function void restart();
    mode = LX_IDLE;
    tok_start = 0;
    byte_pos = 0;
    acc = '0;
    char_count = 0;
    tok_count = 0;
  endfunction

  function bit is_lead(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit hex_nibble(input logic [7:0] c, output logic [63:0] d);
    d = '0;
    if (is_digit(c)) begin
      d = 64'(c - "0");
      return 1;
    end
    if (c >= "a" && c <= "f") begin
      d = 64'(c - "a" + 8'd10);
      return 1;
    end
    if (c >= "A" && c <= "F") begin
      d = 64'(c - "A" + 8'd10);
      return 1;
    end
    return 0;
  endfunction

  function void put(logic [3:0] kind, int off, int len, logic [63:0] val, logic [2:0] cause);
    etok_res_t w;
    if (step_words.size() >= GRP_SLOTS) return;
    w.token_kind = kind;
    w.token_offset = 9'(off);
    w.token_length = 9'(len);
    w.literal_value = val;
    w.error_cause = cause;
    w.run_last = 1'b0;
    step_words.push_back(w);
  endfunction

  // error word, then the rest of the expression is dropped
  function void fail_with(logic [2:0] cause, int off);
    put(KIND_ERROR, off, 0, '0, cause);
    mode = LX_DISCARD;
  endfunction

  function bit add_token(logic [3:0] kind, int off, int len, logic [63:0] val);
    if (tok_count >= tok_cap) begin
      fail_with(CAUSE_TOK_LIMIT, off);
      return 0;
    end
    put(kind, off, len, val, CAUSE_NONE);
    tok_count++;
    return 1;
  endfunction

  // shift in one digit, overflow past 2^64-1 is an error at the literal start
  function void accumulate(logic [63:0] base, logic [63:0] d);
    if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / base) begin
      fail_with(CAUSE_OVERFLOW, tok_start);
      return;
    end
    acc = acc * base + d;
    if (char_count < 511) char_count++;
  endfunction

  function void open_token(logic [7:0] c, int o);
    logic [3:0] kind;
    mode = LX_IDLE;
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
    if (is_lead(c)) begin
      mode = LX_IDENT;
      tok_start = o;
      char_count = 1;
      if (char_count >= ident_cap) fail_with(CAUSE_IDENT_LEN, o);
      return;
    end
    if (is_digit(c)) begin
      tok_start = o;
      acc = 64'(c - "0");
      char_count = 1;
      mode = (c == "0") ? LX_ZERO : LX_DEC;
      return;
    end
    case (c)
      "(": kind = KIND_LPAREN;
      ")": kind = KIND_RPAREN;
      "+": kind = KIND_PLUS;
      "-": kind = KIND_MINUS;
      "*": kind = KIND_STAR;
      "/": kind = KIND_SLASH;
      "%": kind = KIND_PCT;
      default: begin
        fail_with(CAUSE_BAD_CHAR, o);
        return;
      end
    endcase
    void'(add_token(kind, o, 1, '0));
  endfunction

  function void lex_byte(logic [7:0] c, int o);
    logic [63:0] d;
    case (mode)
      LX_IDENT: begin
        if (is_lead(c) || is_digit(c)) begin
          char_count++;
          if (char_count >= ident_cap) fail_with(CAUSE_IDENT_LEN, tok_start);
          return;
        end
        if (add_token(KIND_IDENT, tok_start, o - tok_start, '0)) open_token(c, o);
      end
      LX_ZERO, LX_DEC: begin
        if (mode == LX_ZERO && (c == "x" || c == "X")) begin
          mode = LX_HEXPFX;
          acc = '0;
          char_count = 0;
          return;
        end
        if (is_digit(c)) begin
          mode = LX_DEC;
          accumulate(64'd10, 64'(c - "0"));
          return;
        end
        if (is_lead(c)) begin
          fail_with(CAUSE_BAD_INT, o);
          return;
        end
        if (add_token(KIND_INT, tok_start, o - tok_start, acc)) open_token(c, o);
      end
      LX_HEXPFX, LX_HEX: begin
        if (hex_nibble(c, d)) begin
          mode = LX_HEX;
          accumulate(64'd16, d);
          return;
        end
        if (mode == LX_HEXPFX) begin
          fail_with(CAUSE_BAD_HEX, tok_start);
          return;
        end
        if (is_lead(c)) begin
          fail_with(CAUSE_BAD_INT, o);
          return;
        end
        if (add_token(KIND_INT, tok_start, o - tok_start, acc)) open_token(c, o);
      end
      LX_IDLE: open_token(c, o);
      default: ;
    endcase
  endfunction

  // last byte closes the pending token, then the end token
  function void close_expr(int len);
    bit ok;
    ok = 1;
    case (mode)
      LX_IDENT: ok = add_token(KIND_IDENT, tok_start, len - tok_start, '0);
      LX_ZERO, LX_DEC, LX_HEX: ok = add_token(KIND_INT, tok_start, len - tok_start, acc);
      LX_HEXPFX: begin
        fail_with(CAUSE_BAD_HEX, tok_start);
        ok = 0;
      end
      LX_IDLE: ;
      default: ok = 0;
    endcase
    if (ok) void'(add_token(KIND_END, len, 0, '0));
  endfunction

  // one accepted input word
  function void take_byte(logic [7:0] c, logic fin);
    int o;
    step_words.delete();
    if (mode != LX_DISCARD) begin
      if (byte_pos >= expr_cap) begin
        fail_with(CAUSE_TOO_LONG, 0);
      end else begin
        o = byte_pos;
        lex_byte(c, o);
        if (fin && mode != LX_DISCARD) close_expr(o + 1);
      end
    end
    if (byte_pos < expr_cap) byte_pos++;
    if (fin) restart();
    if (step_words.size() > 0) step_words[step_words.size() - 1].run_last = 1'b1;
    foreach (step_words[i]) tokens_due.push_back(step_words[i]);
  endfunction

  function void flag(string what, logic [63:0] want, logic [63:0] seen);
    errors++;
    $display("%0t mismatch on %s: expected %0h, actual %0h", $time, what, want, seen);
  endfunction

  // one accepted result word against the oldest prediction
  function void match_token(etok_res_t got);
    etok_res_t want;
    if (tokens_due.size() == 0) begin
      errors++;
      $display("%0t unexpected token word: kind %0d offset %0d", $time, got.token_kind,
               got.token_offset);
      return;
    end
    want = tokens_due.pop_front();
    if (got.token_kind !== want.token_kind)
      flag("token_kind", 64'(want.token_kind), 64'(got.token_kind));
    if (got.token_offset !== want.token_offset)
      flag("token_offset", 64'(want.token_offset), 64'(got.token_offset));
    if (got.token_length !== want.token_length)
      flag("token_length", 64'(want.token_length), 64'(got.token_length));
    if (got.literal_value !== want.literal_value)
      flag("literal_value", want.literal_value, got.literal_value);
    if (got.error_cause !== want.error_cause)
      flag("error_cause", 64'(want.error_cause), 64'(got.error_cause));
    if (got.run_last !== want.run_last)
      flag("run_last", 64'(want.run_last), 64'(got.run_last));
  endfunction
endclass

module tb_expression_byte_tokenizer_core;
  localparam int IDENT_CAP = 32;
  localparam int TOK_CAP = 64;
  localparam int EXPR_CAP = 256;

  logic clk = 1'b0;
  logic rst_n;
  bit calm;
  bit hold_req;
  int items_sent;
  logic [7:0] expr_q[$];
  etok_res_t seen_word;

  token_tracker tracker = new(IDENT_CAP, TOK_CAP, EXPR_CAP);

  etok_in_if inb();
  etok_out_if outb();

  expression_byte_tokenizer_core #(
    .MAX_IDENT_BYTES(IDENT_CAP),
    .MAX_TOKENS(TOK_CAP),
    .MAX_EXPR_BYTES(EXPR_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(inb),
    .out_chan(outb)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign seen_word = {outb.token_kind, outb.token_offset, outb.token_length,
                      outb.literal_value, outb.error_cause, outb.run_last};

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && inb.valid && inb.ready) tracker.take_byte(inb.char_byte, inb.final_byte);
    if (rst_n && outb.valid && outb.ready) tracker.match_token(seen_word);
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] lead_pick();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic void add_ident(int n);
    expr_q.push_back(lead_pick());
    for (int i = 1; i < n; i++)
      expr_q.push_back($urandom_range(0, 3) == 0 ? 8'("0" + $urandom_range(0, 9)) : lead_pick());
  endfunction

  function automatic logic [63:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 64'($urandom_range(0, 999));
    if (r < 90) return {$urandom, $urandom} >> $urandom_range(0, 63);
    return '1;
  endfunction

  function automatic void add_dec();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      add_text(r[0] ? "18446744073709551616" : "99999999999999999999");
      return;
    end
    if ($urandom_range(0, 9) == 0) expr_q.push_back("0");
    add_text($sformatf("%0d", pick_value()));
  endfunction

  function automatic void add_hex();
    string s;
    s = ($urandom_range(0, 7) == 0) ? {"1", $sformatf("%016h", pick_value())}
                                    : $sformatf("%0h", pick_value());
    for (int i = 0; i < s.len(); i++)
      if (s[i] >= "a" && s[i] <= "f" && $urandom_range(0, 1)) s[i] = s[i] - 8'd32;
    add_text($urandom_range(0, 1) ? "0x" : "0X");
    add_text(s);
  endfunction

  function automatic void add_space();
    case ($urandom_range(0, 5))
      0: expr_q.push_back(8'h09);
      1: expr_q.push_back(8'h0D);
      2: expr_q.push_back(8'h0A);
      default: expr_q.push_back(" ");
    endcase
  endfunction

  function automatic void add_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) add_ident($urandom_range(0, 19) == 0 ? $urandom_range(30, 33)
                                                     : $urandom_range(1, 6));
    else if (r < 75) add_dec();
    else add_hex();
  endfunction

  function automatic void add_ops(int n);
    string ops;
    ops = "()+-*/%";
    for (int i = 0; i < n; i++) expr_q.push_back(ops[$urandom_range(0, 6)]);
  endfunction

  // well-formed expressions with random content, some broken, some noise
  function automatic void build_random_expr();
    int r;
    int pos;
    string binops;
    binops = "+-*/%";
    expr_q.delete();
    r = $urandom_range(0, 99);
    if (r < 85) begin
      if ($urandom_range(0, 2) == 0) add_space();
      if ($urandom_range(0, 3) == 0) expr_q.push_back("(");
      add_operand();
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        if ($urandom_range(0, 1)) add_space();
        expr_q.push_back(binops[$urandom_range(0, 4)]);
        if ($urandom_range(0, 1)) add_space();
        if ($urandom_range(0, 4) == 0) expr_q.push_back("(");
        add_operand();
        if ($urandom_range(0, 4) == 0) expr_q.push_back(")");
      end
      if ($urandom_range(0, 3) == 0) add_space();
      if (r >= 70) begin
        pos = $urandom_range(0, expr_q.size() - 1);
        if ($urandom_range(0, 1)) expr_q[pos] = 8'($urandom_range(0, 255));
        else expr_q.insert(pos, 8'($urandom_range(0, 255)));
      end
    end else begin
      for (int k = $urandom_range(1, 6); k > 0; k--) expr_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // offer one input word, waiting out a random gap first
  task automatic send_byte(logic [7:0] c, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      inb.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    inb.valid <= 1'b1;
    inb.char_byte <= c;
    inb.final_byte <= fin;
    @(posedge clk);
    while (!inb.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) send_byte(expr_q[i], i == expr_q.size() - 1);
  endtask

  task automatic send_text(string s);
    expr_q.delete();
    add_text(s);
    send_expr();
  endtask

  // sender stops until every predicted word has come back
  task automatic await_drain();
    inb.valid <= 1'b0;
    while (tracker.tokens_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    outb.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        outb.ready <= 1'b0;
        repeat (200) @(negedge clk);
        outb.ready <= 1'b1;
      end else if (stall > 0) begin
        outb.ready <= 1'b0;
        stall--;
      end else begin
        outb.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // stimulus
  initial begin
    int n;
    inb.valid = 1'b0;
    inb.char_byte = 8'h00;
    inb.final_byte = 1'b0;
    rst_n = 1'b0;
    calm = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every operator, extreme bytes, whitespace only, bad hex, bad integer
    send_text("(ab+0x1F)*7/9%_-");
    expr_q.delete();
    expr_q.push_back(8'h00);
    send_expr();
    expr_q.delete();
    expr_q.push_back(8'hFF);
    send_expr();
    send_text(" ");
    send_text("0x");
    send_text("12a");
    await_drain();

    // special cases, the first under a long result-side hold-off
    calm = 1'b0;
    hold_req = 1'b1;
    send_text("18446744073709551615+0xFFFFFFFFFFFFFFFF");
    send_text("0xg");
    send_text("0x1g");
    send_text("7_");
    send_text("0b");
    send_text("a$b");
    expr_q.delete();
    add_ident(IDENT_CAP);
    send_expr();
    // token limit hit by the end token
    expr_q.delete();
    add_ops(TOK_CAP);
    expr_q.push_back(" ");
    send_expr();
    // expression too long with an identifier pending
    expr_q.delete();
    repeat (EXPR_CAP - 6) expr_q.push_back(" ");
    add_text("abcde_xy");
    send_expr();

    // random expressions
    n = 0;
    while (items_sent < 540) begin
      if (n % 4 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 4) await_drain();
      build_random_expr();
      send_expr();
      n++;
    end

    // wait for the last words, with a bound
    inb.valid <= 1'b0;
    for (int w = 0; w < 20000 && tracker.tokens_due.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.tokens_due.size() != 0) begin
      tracker.errors++;
      $display("%0t %0d predicted token words never came", $time, tracker.tokens_due.size());
    end
    if (tracker.errors == 0) begin
      $display("PASS expression_byte_tokenizer_core");
    end else begin
      $display("FAIL expression_byte_tokenizer_core");
    end
    $finish;
  end

  // run limit
  initial begin
    #15000000;
    $display("FAIL expression_byte_tokenizer_core");
    $finish;
  end
endmodule

>>> filelist.f
rtl/etok_pkg.sv
rtl/etok_channels.sv
rtl/etok_lex.sv
rtl/etok_outq.sv
rtl/expression_byte_tokenizer_core.sv
rtl/etok_checker.sv
test/tb_expression_byte_tokenizer_core.sv
